>>> hw/rtl/mff_pkg.sv
package mff_pkg;

    localparam int FRAMES_DEF = 1024;
    localparam int LANES_DEF  = 8;
    localparam int MAX_LANES  = 8;
    localparam int SAMPLE_W   = 32;
    localparam int COUNT_W    = 11;
    localparam int CHAN_W     = 4;

    localparam logic [CHAN_W-1:0] CHAN_RESET = 4'd2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_SKIP  = 2'd2,
        CMD_FLUSH = 2'd3
    } cmd_t;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [MAX_LANES-1:0][SAMPLE_W-1:0] frame_t;

    typedef struct packed {
        cmd_t                command;
        logic [COUNT_W-1:0]  skip_frames;
        logic signed [31:0]  sample_in_lane0;
        logic signed [31:0]  sample_in_lane1;
        logic signed [31:0]  sample_in_lane2;
        logic signed [31:0]  sample_in_lane3;
        logic signed [31:0]  sample_in_lane4;
        logic signed [31:0]  sample_in_lane5;
        logic signed [31:0]  sample_in_lane6;
        logic signed [31:0]  sample_in_lane7;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  frames_moved;
        logic [COUNT_W-1:0]  fill_level;
        logic signed [31:0]  sample_out_lane0;
        logic signed [31:0]  sample_out_lane1;
        logic signed [31:0]  sample_out_lane2;
        logic signed [31:0]  sample_out_lane3;
        logic signed [31:0]  sample_out_lane4;
        logic signed [31:0]  sample_out_lane5;
        logic signed [31:0]  sample_out_lane6;
        logic signed [31:0]  sample_out_lane7;
    } result_t;

    function automatic frame_t frame_of(input in_item_t item);
        frame_t f;
        f[0] = item.sample_in_lane0;
        f[1] = item.sample_in_lane1;
        f[2] = item.sample_in_lane2;
        f[3] = item.sample_in_lane3;
        f[4] = item.sample_in_lane4;
        f[5] = item.sample_in_lane5;
        f[6] = item.sample_in_lane6;
        f[7] = item.sample_in_lane7;
        return f;
    endfunction

    function automatic result_t result_of(input logic [COUNT_W-1:0] moved,
                                          input logic [COUNT_W-1:0] fill,
                                          input frame_t f);
        result_t r;
        r.frames_moved     = moved;
        r.fill_level       = fill;
        r.sample_out_lane0 = f[0];
        r.sample_out_lane1 = f[1];
        r.sample_out_lane2 = f[2];
        r.sample_out_lane3 = f[3];
        r.sample_out_lane4 = f[4];
        r.sample_out_lane5 = f[5];
        r.sample_out_lane6 = f[6];
        r.sample_out_lane7 = f[7];
        return r;
    endfunction

endpackage

>>> hw/rtl/mff_lane.sv
module mff_lane import mff_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(FRAMES)-1:0]  wr_addr,
    input  logic [31:0]                wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(FRAMES)-1:0]  rd_addr,
    output logic [31:0]                rd_data
);

    logic [31:0] store_mem [FRAMES];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/mff_merge.sv
module mff_merge import mff_pkg::*; #(
    parameter int LANES = LANES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [COUNT_W-1:0]              moved,
    input  logic [COUNT_W-1:0]              fill,
    input  logic [MAX_LANES-1:0]            lane_mask,
    input  logic [LANES-1:0][SAMPLE_W-1:0]  rd_data,
    output logic                            done,
    output result_t                         result
);

    logic                 done_reg;
    logic [MAX_LANES-1:0] mask_reg;
    logic [COUNT_W-1:0]   moved_reg;
    logic [COUNT_W-1:0]   fill_reg;
    frame_t               samples;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            mask_reg <= '0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                mask_reg <= lane_mask;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            moved_reg <= moved;
            fill_reg  <= fill;
        end
    end

    // zero for lanes not read
    for (genvar l = 0; l < MAX_LANES; l++)
    begin : g_out
        if (l < LANES)
        begin : g_live
            assign samples[l] = mask_reg[l] ? rd_data[l] : '0;
        end
        else
        begin : g_none
            assign samples[l] = '0;
        end
    end

    assign done   = done_reg;
    assign result = result_of(moved_reg, fill_reg, samples);

endmodule

>>> hw/rtl/multichannel_frame_fifo.sv
// multichannel_frame_fifo: ring buffer of multichannel audio frames
//
// input channel: item carries a command (write, read, skip, flush), a skip
// count and one frame of eight samples; a beat is taken on a clock edge
// with start high and busy low. busy stays low, so one command enters in
// every cycle.
// result channel: exactly one result per command, shown on result for one
// cycle while done is high, in the cycle after the command beat. the receiver
// cannot stall; every command's result appears in order.
// each lane has its own frame memory with a registered read port; the
// result samples come from that read register. pointer update, fill and skip
// clamp complete in the accept cycle, so throughput is one command a cycle.
// config channel: cfg_data sets the active channel count (0 acts as 1,
// above LANES acts as LANES); cfg_ready is always high. write it only
// while no result is pending.
// reset empties the buffer (both pointers zero) and sets two channels.
// FRAMES must be a power of two.
module multichannel_frame_fifo import mff_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF,
    parameter int LANES  = LANES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  in_item_t          item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CHAN_W-1:0] cfg_data,
    output logic              done,
    output result_t           result
);

    localparam int ADDR_W = $clog2(FRAMES);
    localparam int PTR_W  = ADDR_W + 1;
    localparam int CMP_W  = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;

    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CHAN_W-1:0]  chan_reg;
    logic [CHAN_W-1:0]  nch;
    logic [PTR_W-1:0]   fill;
    logic [CMP_W-1:0]   fill_ext;
    logic [CMP_W-1:0]   req_ext;
    logic [CMP_W-1:0]   moved;
    logic [CMP_W-1:0]   fill_after;
    logic               accept;
    logic               wr_ok;
    logic               rd_ok;
    logic [MAX_LANES-1:0]           lane_mask;
    frame_t                         frame_in;
    logic [LANES-1:0][SAMPLE_W-1:0] rd_data;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    always_comb
    begin
        if (chan_reg == '0)
        begin
            nch = CHAN_W'(1);
        end
        else if (chan_reg > CHAN_W'(LANES))
        begin
            nch = CHAN_W'(LANES);
        end
        else
        begin
            nch = chan_reg;
        end
    end

    assign fill     = wr_ptr_reg - rd_ptr_reg;
    assign fill_ext = CMP_W'(fill);
    assign req_ext  = CMP_W'(item.skip_frames);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ok       = 1'b0;
        rd_ok       = 1'b0;
        moved       = '0;
        fill_after  = fill_ext;
        case (item.command)
            CMD_WRITE:
            begin
                if (fill != PTR_W'(FRAMES))
                begin
                    wr_ok       = 1'b1;
                    wr_ptr_next = wr_ptr_reg + PTR_W'(1);
                    moved       = CMP_W'(1);
                    fill_after  = fill_ext + CMP_W'(1);
                end
            end
            CMD_READ:
            begin
                if (fill != '0)
                begin
                    rd_ok       = 1'b1;
                    rd_ptr_next = rd_ptr_reg + PTR_W'(1);
                    moved       = CMP_W'(1);
                    fill_after  = fill_ext - CMP_W'(1);
                end
            end
            CMD_SKIP:
            begin
                moved       = (req_ext > fill_ext) ? fill_ext : req_ext;
                rd_ptr_next = rd_ptr_reg + PTR_W'(moved);
                fill_after  = fill_ext - moved;
            end
            CMD_FLUSH:
            begin
                rd_ptr_next = wr_ptr_reg;
                fill_after  = '0;
            end
            default:
            begin
                fill_after = fill_ext;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            chan_reg   <= CHAN_RESET;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= rd_ptr_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                chan_reg <= cfg_data;
            end
        end
    end

    assign frame_in = frame_of(item);

    for (genvar l = 0; l < MAX_LANES; l++)
    begin : g_mask
        if (l < LANES)
        begin : g_live
            assign lane_mask[l] = rd_ok && (CHAN_W'(l) < nch);
        end
        else
        begin : g_none
            assign lane_mask[l] = 1'b0;
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        mff_lane #(
            .FRAMES (FRAMES)
        ) u_lane (
            .clk     (clk),
            .wr_en   (accept && wr_ok),
            .wr_addr (wr_ptr_reg[ADDR_W-1:0]),
            .wr_data ((CHAN_W'(l) < nch) ? frame_in[l] : '0),
            .rd_en   (accept && rd_ok),
            .rd_addr (rd_ptr_reg[ADDR_W-1:0]),
            .rd_data (rd_data[l])
        );
    end

    mff_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .moved     (moved[COUNT_W-1:0]),
        .fill      (fill_after[COUNT_W-1:0]),
        .lane_mask (lane_mask),
        .rd_data   (rd_data),
        .done      (done),
        .result    (result)
    );

endmodule

>>> verif/mff_checker.sv
`timescale 1ns / 1ps

module mff_checker
    import mff_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF,
    parameter int LANES  = LANES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  in_item_t          item,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CHAN_W-1:0] cfg_data,
    input  logic              done,
    input  result_t           result,
    output int                errors,
    output int                outstanding
);

    localparam int SPAN = 2 * FRAMES;

    sample_t           slot_store [FRAMES][MAX_LANES];
    int                wr_cnt;
    int                rd_cnt;
    logic [CHAN_W-1:0] chan_reg;
    result_t           results_due [$];
    result_t           want_r;
    logic [$bits(result_t)-1:0] want_raw;
    logic [$bits(result_t)-1:0] got_raw;

    function automatic int lanes_active(input logic [CHAN_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > LANES)
            return LANES;
        return int'(c);
    endfunction

    // advances the buffer state by one command and returns its result
    function automatic result_t next_fifo_result(input in_item_t it);
        logic [$bits(in_item_t)-1:0] in_raw;
        logic [$bits(result_t)-1:0]  out_raw;
        result_t                     r;
        int                          nch;
        int                          fill;
        int                          moved;
        int                          slot;
        in_raw  = it;
        out_raw = '0;
        nch     = lanes_active(chan_reg);
        fill    = (wr_cnt - rd_cnt + SPAN) % SPAN;
        moved   = 0;
        case (it.command)
            CMD_WRITE:
            begin
                if (fill < FRAMES)
                begin
                    slot = wr_cnt % FRAMES;
                    for (int l = 0; l < MAX_LANES; l++)
                        slot_store[slot][l] = (l < nch) ?
                            in_raw[(MAX_LANES-1-l)*SAMPLE_W +: SAMPLE_W] : '0;
                    wr_cnt = (wr_cnt + 1) % SPAN;
                    moved  = 1;
                end
            end
            CMD_READ:
            begin
                if (fill > 0)
                begin
                    slot = rd_cnt % FRAMES;
                    for (int l = 0; l < MAX_LANES; l++)
                        if (l < nch)
                            out_raw[(MAX_LANES-1-l)*SAMPLE_W +: SAMPLE_W] = slot_store[slot][l];
                    rd_cnt = (rd_cnt + 1) % SPAN;
                    moved  = 1;
                end
            end
            CMD_SKIP:
            begin
                moved  = (int'(it.skip_frames) > fill) ? fill : int'(it.skip_frames);
                rd_cnt = (rd_cnt + moved) % SPAN;
            end
            CMD_FLUSH:
            begin
                rd_cnt = wr_cnt;
            end
        endcase
        fill           = (wr_cnt - rd_cnt + SPAN) % SPAN;
        r              = out_raw;
        r.frames_moved = COUNT_W'(moved);
        r.fill_level   = COUNT_W'(fill);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [SAMPLE_W-1:0] want,
                               input logic [SAMPLE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_due.delete();
            wr_cnt      = 0;
            rd_cnt      = 0;
            chan_reg    = CHAN_RESET;
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result beat with no command waiting");
                    errors++;
                end
                else
                begin
                    want_r   = results_due.pop_front();
                    want_raw = want_r;
                    got_raw  = result;
                    check_field("frames_moved", SAMPLE_W'(want_r.frames_moved),
                                SAMPLE_W'(result.frames_moved));
                    check_field("fill_level", SAMPLE_W'(want_r.fill_level),
                                SAMPLE_W'(result.fill_level));
                    for (int l = 0; l < MAX_LANES; l++)
                        check_field($sformatf("sample_out_lane%0d", l),
                                    want_raw[(MAX_LANES-1-l)*SAMPLE_W +: SAMPLE_W],
                                    got_raw[(MAX_LANES-1-l)*SAMPLE_W +: SAMPLE_W]);
                end
            end
            if (start && !busy)
                results_due.push_back(next_fifo_result(item));
            if (cfg_valid && cfg_ready)
                chan_reg = cfg_data;
            outstanding = results_due.size();
        end
    end

endmodule

>>> verif/tb_multichannel_frame_fifo.sv
`timescale 1ns / 1ps

module tb_multichannel_frame_fifo;

    import mff_pkg::*;

    localparam int FRAMES     = FRAMES_DEF;
    localparam int LANES      = LANES_DEF;
    localparam int IDLE_LIMIT = 4000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    in_item_t          item;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CHAN_W-1:0] cfg_data;
    logic              done;
    result_t           result;
    int                errors;
    int                outstanding;
    int                burst_left;
    int                idle_count;
    int                write_pct [6] = '{55, 70, 30, 50, 60, 45};

    multichannel_frame_fifo #(
        .FRAMES (FRAMES),
        .LANES  (LANES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    mff_checker #(
        .FRAMES (FRAMES),
        .LANES  (LANES)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .done        (done),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // stall watchdog
    initial
    begin
        idle_count = 0;
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic frame_t rand_frame();
        frame_t f;
        for (int l = 0; l < MAX_LANES; l++)
            f[l] = rand_sample();
        return f;
    endfunction

    function automatic in_item_t make_item(input cmd_t c, input int n, input frame_t f);
        in_item_t it;
        it.command         = c;
        it.skip_frames     = COUNT_W'(n);
        it.sample_in_lane0 = f[0];
        it.sample_in_lane1 = f[1];
        it.sample_in_lane2 = f[2];
        it.sample_in_lane3 = f[3];
        it.sample_in_lane4 = f[4];
        it.sample_in_lane5 = f[5];
        it.sample_in_lane6 = f[6];
        it.sample_in_lane7 = f[7];
        return it;
    endfunction

    function automatic in_item_t rand_item(input int wpct);
        int   r;
        int   rpct;
        cmd_t c;
        int   n;
        r    = $urandom_range(0, 99);
        rpct = (100 - wpct) * 3 / 4;
        if (r < wpct)
            c = CMD_WRITE;
        else if (r < wpct + rpct)
            c = CMD_READ;
        else if (r < 97)
            c = CMD_SKIP;
        else
            c = CMD_FLUSH;
        if ($urandom_range(0, 3) == 0)
            n = $urandom_range(0, 2047);
        else
            n = $urandom_range(0, 8);
        return make_item(c, n, rand_frame());
    endfunction

    // one command beat, then maybe a gap that ends the burst
    task automatic send_item(input in_item_t it);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_channels(input int v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= CHAN_W'(v);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_data   = CHAN_RESET;
        burst_left = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty buffer cases at reset channel count
        send_item(make_item(CMD_READ, 0, '0));
        send_item(make_item(CMD_SKIP, 5, '0));
        send_item(make_item(CMD_FLUSH, 0, '0));
        send_item(make_item(CMD_WRITE, 0, {8{32'h7fff_ffff}}));
        send_item(make_item(CMD_READ, 0, '0));

        write_channels(8);
        send_item(make_item(CMD_WRITE, 0, {8{32'h8000_0000}}));
        send_item(make_item(CMD_WRITE, 0, {8{32'h7fff_ffff}}));
        send_item(make_item(CMD_WRITE, 0, '0));
        send_item(make_item(CMD_WRITE, 0, {8{32'hffff_ffff}}));
        send_item(make_item(CMD_WRITE, 0, {4{32'h5555_5555, 32'haaaa_aaaa}}));
        send_item(make_item(CMD_SKIP, 0, '0));
        send_item(make_item(CMD_READ, 0, '0));
        send_item(make_item(CMD_SKIP, 2, '0));
        send_item(make_item(CMD_SKIP, 2047, '0));
        send_item(make_item(CMD_READ, 0, '0));
        send_item(make_item(CMD_WRITE, 0, rand_frame()));
        send_item(make_item(CMD_WRITE, 0, rand_frame()));
        send_item(make_item(CMD_FLUSH, 0, '0));
        send_item(make_item(CMD_READ, 0, '0));
        send_item(make_item(CMD_WRITE, 0, {8{32'h8000_0001}}));
        send_item(make_item(CMD_WRITE, 0, {8{32'h7fff_fffe}}));

        // narrower, zero and oversized channel counts
        write_channels(1);
        send_item(make_item(CMD_READ, 0, '0));
        write_channels(0);
        send_item(make_item(CMD_READ, 0, '0));
        write_channels(15);
        send_item(make_item(CMD_WRITE, 0, rand_frame()));
        send_item(make_item(CMD_READ, 0, '0));

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: write_channels(1);
                1: write_channels(8);
                2: write_channels(0);
                3: write_channels(15);
                default: write_channels($urandom_range(0, 15));
            endcase
            repeat (80) send_item(rand_item(write_pct[p]));
        end

        // balanced traffic at the last channel count
        repeat (40) send_item(rand_item(50));

        drain();
        repeat (5) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
